FILE: rtl/core/windowed_pulse_rate_estimator_core_macros.svh
// assertion macros used by the pulse rate estimator core
`ifndef WINDOWED_PULSE_RATE_ESTIMATOR_CORE_MACROS_SVH
`define WINDOWED_PULSE_RATE_ESTIMATOR_CORE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define WPRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define WPRE_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/core/wpre_pkg.sv
// types and constants of the windowed pulse rate estimator
package wpre_pkg;

	// width of counter snapshots and of the rate
	localparam int DATA_W = 16;
	// divider step counter, one quotient bit per step
	localparam int DIV_CNT_W = $clog2(DATA_W);

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	// divider request
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
	} div_ctl_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

FILE: rtl/core/windowed_pulse_rate_estimator_core.sv
// top level of the windowed pulse rate estimator
//
// Usage: each snapshot transaction on the snap channel (snap_valid, snap_stall,
// count_snapshot) carries one sample of a free-running 16-bit pulse counter.
// The block stores it in a ring of WINDOW entries held in a synchronous RAM
// and returns one rate transaction (pulse_rate, window_full) on the rate
// channel (rate_valid, rate_stall). Once the ring has wrapped the rate is
// (newest - oldest) * 2; before that it is (newest - first) * 2 * WINDOW
// divided by the number of stored samples, all modulo 2^16.
// Once the ring is full a result passes the RAM read, the subtract into
// rate_q and the output register; before that the scaled difference also
// goes through the bit-serial divider, which forms its 16 quotient bits.
// One snapshot is in flight at a time; snap_stall is high while it is
// processed and while its result waits, so a new snapshot is taken only
// once the previous one has reached the output register.
// Reset clears the write position and the full flag; ring contents are
// never used before written. A result held by rate_stall sits in the
// output register; the next snapshot is still accepted and its result
// waits until the output register is free.
`include "windowed_pulse_rate_estimator_core_macros.svh"

module windowed_pulse_rate_estimator_core #(
	parameter int WINDOW = 60
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        snap_valid,
	output logic                        snap_stall,
	input  logic [wpre_pkg::DATA_W-1:0] count_snapshot,
	output logic                        rate_valid,
	input  logic                        rate_stall,
	output logic [wpre_pkg::DATA_W-1:0] pulse_rate,
	output logic                        window_full
);
	import wpre_pkg::*;

	localparam int                 POS_W    = $clog2(WINDOW);
	localparam logic [POS_W-1:0]   LAST_POS = POS_W'(WINDOW - 1);
	localparam logic [DATA_W-1:0]  WINDOW_D = DATA_W'(WINDOW);

	state_t            state_q;
	logic [POS_W-1:0]  pos_q;
	logic              filled_q;
	logic [DATA_W-1:0] ring_mem [WINDOW];
	logic [DATA_W-1:0] rdata_q;

	logic [DATA_W-1:0] snap_s1;
	logic              bypass_s1;
	logic              filled_s1;
	logic [POS_W-1:0]  count_s1;
	logic [DATA_W-1:0] diff2_s2;
	logic [DATA_W-1:0] rate_q;

	logic              rate_valid_q;
	logic [DATA_W-1:0] pulse_rate_q;
	logic              window_full_q;

	logic              accept;
	logic              pos_wrap;
	logic [POS_W-1:0]  pos_next;
	logic              filled_next;
	logic [POS_W-1:0]  rd_addr;
	logic [DATA_W-1:0] oldest;
	logic [DATA_W-1:0] diff;
	logic [DATA_W-1:0] diff2;
	logic              out_load;

	div_ctl_t          div_ctl;
	div_sts_t          div_sts;
	logic [DATA_W-1:0] div_quo;

	// input handshake
	assign snap_stall = (state_q != ST_IDLE);
	assign accept     = snap_valid && !snap_stall;

	// ring position bookkeeping
	assign pos_wrap    = (pos_q == LAST_POS);
	assign pos_next    = pos_wrap ? '0 : pos_q + 1'b1;
	assign filled_next = filled_q | pos_wrap;
	assign rd_addr     = filled_next ? pos_next : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_next;
			filled_q <= filled_next;
		end
	end

	// snapshot ring: write newest, read oldest or first entry
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[pos_q] <= count_snapshot;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= ring_mem[rd_addr];
		end
	end

	// stage 1 capture
	always_ff @(posedge clk) begin
		if (accept) begin
			snap_s1   <= count_snapshot;
			bypass_s1 <= !filled_next && (pos_q == '0);
			filled_s1 <= filled_next;
			count_s1  <= pos_next;
		end
	end

	// difference times two, first sample compares with itself
	assign oldest = bypass_s1 ? snap_s1 : rdata_q;
	assign diff   = snap_s1 - oldest;
	assign diff2  = {diff[DATA_W-2:0], 1'b0};

	// scale to full window and start division
	assign div_ctl.start    = (state_q == ST_MUL);
	assign div_ctl.dividend = diff2_s2 * WINDOW_D;

	wpre_div #(
		.DVSR_W (POS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.divisor  (count_s1),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= filled_s1 ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_sts.done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			diff2_s2 <= diff2;
			rate_q   <= diff2;
		end else if (state_q == ST_DIV && div_sts.done) begin
			rate_q <= div_quo;
		end
	end

	// output register
	assign out_load = (state_q == ST_DONE) && (!rate_valid_q || !rate_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_valid_q <= 1'b0;
		end else if (out_load) begin
			rate_valid_q <= 1'b1;
		end else if (!rate_stall) begin
			rate_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pulse_rate_q  <= rate_q;
			window_full_q <= filled_s1;
		end
	end

	assign rate_valid  = rate_valid_q;
	assign pulse_rate  = pulse_rate_q;
	assign window_full = window_full_q;

	// checks
	`WPRE_NEVER(a_div_done_state, div_sts.done && (state_q != ST_DIV), "divider done outside DIV")
	`WPRE_NEVER(a_pos_range, pos_q > LAST_POS, "write position beyond ring")
	`WPRE_ASSERT(a_fill_sticky, filled_q |=> filled_q, "ring full flag dropped")
	`WPRE_ASSERT(a_accept_read, accept |=> (state_q == ST_RD), "accepted snapshot not read")
	`WPRE_NEVER(a_div_idle_busy, div_sts.busy && (state_q == ST_IDLE), "divider busy while idle")

endmodule

FILE: rtl/core/wpre_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module wpre_div #(
	parameter int DVSR_W = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wpre_pkg::div_ctl_t             ctl,
	input  logic [DVSR_W-1:0]              divisor,
	output wpre_pkg::div_sts_t             sts,
	output logic [wpre_pkg::DATA_W-1:0]    quotient
);
	import wpre_pkg::*;

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DATA_W - 1);

	logic [DVSR_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DVSR_W-1:0]    dvsr_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVSR_W:0]      shifted;
	logic [DVSR_W+1:0]    trial;

	// shift in next dividend bit and try subtracting the divisor
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= '0;
			quo_q  <= ctl.dividend;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DVSR_W+1]) begin
				rem_q <= trial[DVSR_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVSR_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

FILE: test/tb.sv
// self-checking testbench for the windowed pulse rate estimator core
module tb;
	import wpre_pkg::*;

	localparam int SNAP_W      = DATA_W;
	localparam int RING_DEPTH  = 60;
	localparam int DIR_N       = 14;
	localparam int RAND_N      = 1936;
	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		logic [SNAP_W-1:0] rate;
		logic              full;
	} rate_exp_t;

	typedef struct {
		logic [SNAP_W-1:0] snap;
		bit                known;
		logic [SNAP_W-1:0] rate;
		logic              full;
	} snap_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              snap_valid = 1'b0;
	logic              snap_stall;
	logic [SNAP_W-1:0] count_snapshot = '0;
	logic              rate_valid;
	logic              rate_stall = 1'b0;
	logic [SNAP_W-1:0] pulse_rate;
	logic              window_full;

	// directed snapshots; expected rate typed in where it is obvious
	snap_row_t dir_rows [DIR_N] = '{
		'{16'hFFF0, 1'b1, 16'h0000, 1'b0},	// first sample after reset
		'{16'hFFF0, 1'b1, 16'h0000, 1'b0},	// no pulses since first sample
		'{16'h0010, 1'b0, 16'h0000, 1'b0},	// counter wrapped between samples
		'{16'h0000, 1'b0, 16'h0000, 1'b0},
		'{16'hFFFF, 1'b0, 16'h0000, 1'b0},	// snapshot at its maximum
		'{16'hFFEF, 1'b0, 16'h0000, 1'b0},	// largest span
		'{16'h8000, 1'b0, 16'h0000, 1'b0},
		'{16'h7FFF, 1'b0, 16'h0000, 1'b0},
		'{16'h5555, 1'b0, 16'h0000, 1'b0},
		'{16'hAAAA, 1'b0, 16'h0000, 1'b0},
		'{16'h0001, 1'b0, 16'h0000, 1'b0},
		'{16'hFFF1, 1'b0, 16'h0000, 1'b0},	// small span, product fits
		'{16'h0000, 1'b0, 16'h0000, 1'b0},
		'{16'hFFFF, 1'b0, 16'h0000, 1'b0}
	};

	// predictor state: history of snapshots and the next slot
	logic [SNAP_W-1:0] hist_ring [RING_DEPTH];
	int unsigned       hist_slot = 0;
	logic              hist_wrapped = 1'b0;

	rate_exp_t   rate_q [$];
	int unsigned snap_cnt = 0;
	int unsigned rate_cnt = 0;
	int unsigned full_cnt = 0;
	int unsigned input_stall_cnt = 0;
	int unsigned hold_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned burst_left = 1;
	logic [SNAP_W-1:0] pulse_cnt = '0;

	windowed_pulse_rate_estimator_core #(
		.WINDOW(RING_DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap_stall    (snap_stall),
		.count_snapshot(count_snapshot),
		.rate_valid    (rate_valid),
		.rate_stall    (rate_stall),
		.pulse_rate    (pulse_rate),
		.window_full   (window_full)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// cycle counter and watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("[%0t] run timed out after %0d cycles", $time, cycle_cnt);
		$display("tb: failure");
		$finish;
	end

	// store a snapshot and work out the rate it yields
	function automatic rate_exp_t estimate_rate(input logic [SNAP_W-1:0] snap);
		rate_exp_t         res;
		int unsigned       newest;
		int unsigned       stored;
		logic [SNAP_W-1:0] span;
		logic [31:0]       prod;
		newest = hist_slot;
		hist_ring[newest] = snap;
		hist_slot = (newest + 1 == RING_DEPTH) ? 0 : newest + 1;
		if (hist_slot == 0) begin
			hist_wrapped = 1'b1;
		end
		if (hist_wrapped) begin
			// oldest entry sits at the next write slot
			span = snap - hist_ring[hist_slot];
			res.rate = {span[SNAP_W-2:0], 1'b0};
		end else begin
			// scale the span since the first sample to a whole window
			stored = hist_slot;
			span = snap - hist_ring[0];
			prod = 32'({span[SNAP_W-2:0], 1'b0}) * RING_DEPTH;
			res.rate = SNAP_W'(prod[SNAP_W-1:0] / stored);
		end
		res.full = hist_wrapped;
		return res;
	endfunction

	// compare rate transactions, then predict for accepted snapshots
	always @(posedge clk) begin
		rate_exp_t   got;
		rate_exp_t   fresh;
		if (arst_n) begin
			if (rate_valid && !rate_stall) begin
				rate_cnt++;
				if (window_full === 1'b1) begin
					full_cnt++;
				end
				if (rate_q.size() == 0) begin
					$display("[%0t] unexpected rate transaction: rate %h full %b",
						$time, pulse_rate, window_full);
					err_cnt++;
				end else begin
					got = rate_q.pop_front();
					if (pulse_rate !== got.rate) begin
						$display("[%0t] pulse_rate mismatch: expected %h actual %h",
							$time, got.rate, pulse_rate);
						err_cnt++;
					end
					if (window_full !== got.full) begin
						$display("[%0t] window_full mismatch: expected %b actual %b",
							$time, got.full, window_full);
						err_cnt++;
					end
				end
			end
			if (snap_valid && snap_stall) begin
				input_stall_cnt++;
			end
			if (snap_valid && !snap_stall) begin
				fresh = estimate_rate(count_snapshot);
				if (snap_cnt < DIR_N && dir_rows[snap_cnt].known) begin
					fresh.rate = dir_rows[snap_cnt].rate;
					fresh.full = dir_rows[snap_cnt].full;
				end
				rate_q.push_back(fresh);
				snap_cnt++;
			end
		end
	end

	// offer one snapshot until taken, then maybe pause between bursts
	task automatic send_snapshot(input logic [SNAP_W-1:0] value);
		snap_valid <= 1'b1;
		count_snapshot <= value;
		@(posedge clk);
		while (snap_stall) begin
			@(posedge clk);
		end
		burst_left--;
		if (burst_left == 0) begin
			snap_valid <= 1'b0;
			count_snapshot <= SNAP_W'($urandom);
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
		end
	endtask

	// receiver: stall patterns, plus long hold-offs to back up the input
	initial begin
		int unsigned mode;
		int unsigned run_len;
		int unsigned period;
		int unsigned duty;
		int unsigned tick;
		int unsigned next_hold;
		next_hold = 150;
		@(posedge clk);
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			if (rate_cnt >= next_hold) begin
				rate_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_cnt++;
				next_hold = rate_cnt + 900;
			end else begin
				mode = $urandom_range(0, 3);
				run_len = $urandom_range(10, 150);
				period = $urandom_range(2, 9);
				duty = $urandom_range(1, period - 1);
				for (tick = 0; tick < run_len; tick++) begin
					case (mode)
						0: rate_stall <= 1'b0;
						1: rate_stall <= ($urandom_range(0, 1) == 1);
						2: rate_stall <= ($urandom_range(0, 3) != 0);
						default: rate_stall <= ((tick % period) < duty);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned i;
		int unsigned seg_left;
		int unsigned step_max;
		bit          noise;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed snapshots
		for (i = 0; i < DIR_N; i++) begin
			send_snapshot(dir_rows[i].snap);
		end

		// random part: mostly a running counter, some noise
		pulse_cnt = dir_rows[DIR_N-1].snap;
		seg_left = 0;
		step_max = 0;
		noise = 1'b0;
		for (i = 0; i < RAND_N; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(5, 120);
				noise = ($urandom_range(0, 4) == 0);
				case ($urandom_range(0, 4))
					0: step_max = 3;
					1: step_max = 200;
					2: step_max = 2000;
					3: step_max = 40000;
					default: step_max = 65535;
				endcase
			end
			seg_left--;
			if (noise) begin
				send_snapshot(SNAP_W'($urandom));
			end else begin
				pulse_cnt = pulse_cnt + SNAP_W'($urandom_range(0, step_max));
				send_snapshot(pulse_cnt);
			end
		end
		snap_valid <= 1'b0;
		@(posedge clk);

		// drain outstanding rates, then watch for strays
		while (rate_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("run covered %0d snapshot transactions and %0d rate transactions",
			snap_cnt, rate_cnt);
		$display("%0d rates with a full window, %0d hold-offs, %0d input stall cycles",
			full_cnt, hold_cnt, input_stall_cnt);
		if (err_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/wpre_pkg.sv
rtl/core/wpre_div.sv
rtl/core/windowed_pulse_rate_estimator_core.sv
test/tb.sv
